### sv/csolve_pkg.sv
// shared constants, types and term tables for the cramer 3x3 solve unit
// no dependencies
package csolve_pkg;

    localparam int IN_WIDTH_DEF      = 16;
    localparam int OUT_FRAC_BITS_DEF = 16;
    localparam int QW                = 32;
    localparam int LANE_LAT          = QW + 2;
    localparam int DET_LAT           = 3;

    localparam logic [QW-1:0] SAT_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] SAT_NEG = {1'b1, {(QW-1){1'b0}}};

    // six triple products of a row-major 3x3 determinant
    localparam int TERM_A [6] = '{0, 2, 1, 2, 1, 0};
    localparam int TERM_B [6] = '{4, 3, 5, 4, 3, 5};
    localparam int TERM_C [6] = '{8, 7, 6, 6, 8, 7};
    localparam bit TERM_NEG [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    typedef struct packed {
        logic [QW-1:0] value;
        logic          sat;
    } cs_quot_t;

endpackage

### sv/cramer_3x3_linear_solve_unit.sv
// cramer's rule 3x3 solver: four determinant pipeline and three divider lanes
// depends on csolve_pkg, cs_det_unit, cs_div_lane
//
// usage
//   one word holds the three matrix columns and the rhs vector, signed Q7.8.
//   a word is taken at a rising edge with start high and busy low; busy is
//   always low, so a new word may be given in every cycle.
//   the result word (sol_x, sol_y, sol_z in Q15.16, singular, overflow) is
//   shown for exactly one cycle with done high.
//   throughput one word per cycle. a word passes the three determinant stages
//   (pair product, triple product, sum) and then the divider lanes, one
//   quotient bit per stage.
//   a zero main determinant gives zero solutions with singular set; quotients
//   out of range saturate and set overflow.
//   reset clears the valid bits of every stage; words in flight are dropped.
//   the receiver cannot stall: every result appears once, in order.
module cramer_3x3_linear_solve_unit
    import csolve_pkg::*;
#(
    parameter int IN_WIDTH      = IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [IN_WIDTH-1:0] col1_x,
    input  logic signed [IN_WIDTH-1:0] col1_y,
    input  logic signed [IN_WIDTH-1:0] col1_z,
    input  logic signed [IN_WIDTH-1:0] col2_x,
    input  logic signed [IN_WIDTH-1:0] col2_y,
    input  logic signed [IN_WIDTH-1:0] col2_z,
    input  logic signed [IN_WIDTH-1:0] col3_x,
    input  logic signed [IN_WIDTH-1:0] col3_y,
    input  logic signed [IN_WIDTH-1:0] col3_z,
    input  logic signed [IN_WIDTH-1:0] rhs_x,
    input  logic signed [IN_WIDTH-1:0] rhs_y,
    input  logic signed [IN_WIDTH-1:0] rhs_z,
    output logic                       done,
    output logic signed [QW-1:0]       sol_x,
    output logic signed [QW-1:0]       sol_y,
    output logic signed [QW-1:0]       sol_z,
    output logic                       singular,
    output logic                       overflow
);

    localparam int DW  = 3 * IN_WIDTH + 2;
    localparam int LAT = DET_LAT + LANE_LAT + 1;

    logic signed [IN_WIDTH-1:0] mat_a [9];
    logic signed [IN_WIDTH-1:0] vec_b [3];
    logic signed [DW-1:0]       det [4];
    logic                       det_vld;
    cs_quot_t                   quot [3];

    logic [LANE_LAT-1:0]        vld_pipe_reg;
    logic [LANE_LAT-1:0]        sing_pipe_reg;
    logic                       done_reg;
    logic [QW-1:0]              sol_reg [3];
    logic                       sing_reg;
    logic                       ovf_reg;
    logic                       sing_cur;

    // row-major: row r holds component r of each column
    assign mat_a = '{col1_x, col2_x, col3_x,
                     col1_y, col2_y, col3_y,
                     col1_z, col2_z, col3_z};
    assign vec_b = '{rhs_x, rhs_y, rhs_z};

    cs_det_unit #(
        .IN_WIDTH (IN_WIDTH),
        .DW       (DW)
    ) u_det (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start),
        .a       (mat_a),
        .b       (vec_b),
        .out_vld (det_vld),
        .det     (det)
    );

    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        cs_div_lane #(
            .DW            (DW),
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .num (det[j+1]),
            .den (det[0]),
            .res (quot[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_pipe_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            vld_pipe_reg <= {vld_pipe_reg[LANE_LAT-2:0], det_vld};
            done_reg     <= vld_pipe_reg[LANE_LAT-1];
        end
    end

    assign sing_cur = (det[0] == '0);

    always_ff @(posedge clk)
    begin
        sing_pipe_reg <= {sing_pipe_reg[LANE_LAT-2:0], sing_cur};
        sing_reg      <= sing_pipe_reg[LANE_LAT-1];
        ovf_reg       <= !sing_pipe_reg[LANE_LAT-1] &&
                         (quot[0].sat || quot[1].sat || quot[2].sat);
        for (int j = 0; j < 3; j++)
        begin
            sol_reg[j] <= sing_pipe_reg[LANE_LAT-1] ? '0 : quot[j].value;
        end
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign sol_x    = sol_reg[0];
    assign sol_y    = sol_reg[1];
    assign sol_z    = sol_reg[2];
    assign singular = sing_reg;
    assign overflow = ovf_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("accepted word did not come out after the pipeline latency");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("done without a matching accepted word");

    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        (done && singular) |-> (sol_x == '0 && sol_y == '0 && sol_z == '0 && !overflow))
        else $error("singular result with nonzero solution or overflow");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !overflow && !singular) |-> $past(det_vld, LANE_LAT + 1))
        else $error("result not aligned with determinant stage");

endmodule

### sv/cs_det_unit.sv
// three-stage pipeline forming the main and the three replaced-column determinants
// depends on csolve_pkg
module cs_det_unit
    import csolve_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF,
    parameter int DW       = 3 * IN_WIDTH + 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic signed [IN_WIDTH-1:0] a [9],
    input  logic signed [IN_WIDTH-1:0] b [3],
    output logic                       out_vld,
    output logic signed [DW-1:0]       det [4]
);

    localparam int PW = 2 * IN_WIDTH;
    localparam int TW = 3 * IN_WIDTH;

    logic signed [IN_WIDTH-1:0] mat [4][9];
    logic signed [PW-1:0]       p_reg [4][6];
    logic signed [IN_WIDTH-1:0] c_reg [4][6];
    logic signed [TW-1:0]       t_reg [4][6];
    logic signed [DW-1:0]       det_reg [4];
    logic signed [DW-1:0]       det_next [4];
    logic [DET_LAT-1:0]         vld_reg;

    // matrix 0 is the system matrix, matrix i has column i-1 replaced by the rhs
    always_comb
    begin
        for (int mi = 0; mi < 4; mi++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (mi != 0 && c == mi - 1)
                        mat[mi][r*3+c] = b[r];
                    else
                        mat[mi][r*3+c] = a[r*3+c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int mi = 0; mi < 4; mi++)
        begin
            for (int k = 0; k < 6; k++)
            begin
                p_reg[mi][k] <= mat[mi][TERM_A[k]] * mat[mi][TERM_B[k]];
                c_reg[mi][k] <= mat[mi][TERM_C[k]];
                t_reg[mi][k] <= p_reg[mi][k] * c_reg[mi][k];
            end
            det_reg[mi] <= det_next[mi];
        end
    end

    always_comb
    begin
        for (int mi = 0; mi < 4; mi++)
        begin
            det_next[mi] = '0;
            for (int k = 0; k < 6; k++)
            begin
                if (TERM_NEG[k])
                    det_next[mi] = det_next[mi] - DW'(t_reg[mi][k]);
                else
                    det_next[mi] = det_next[mi] + DW'(t_reg[mi][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[DET_LAT-2:0], in_vld};
    end

    assign out_vld = vld_reg[DET_LAT-1];
    assign det     = det_reg;

endmodule

### sv/cs_div_lane.sv
// pipelined restoring divider, one quotient bit per stage, with saturation
// depends on csolve_pkg
module cs_div_lane
    import csolve_pkg::*;
#(
    parameter int DW            = 50,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic signed [DW-1:0] num,
    input  logic signed [DW-1:0] den,
    output cs_quot_t             res
);

    localparam int RW = DW + 1;
    localparam int PW = DW + OUT_FRAC_BITS;
    localparam int HW = PW - QW;

    logic [DW-1:0] n_mag;
    logic [DW-1:0] d_mag;
    logic [PW-1:0] p_num;
    logic [RW-1:0] rem_init;

    logic [RW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] q_reg   [QW+1];
    logic [DW-1:0] d_reg   [QW+1];
    logic          neg_reg [QW+1];
    logic          sat_reg [QW+1];
    cs_quot_t      res_reg;
    cs_quot_t      res_next;

    always_comb
    begin
        n_mag    = num[DW-1] ? (~num + DW'(1)) : num;
        d_mag    = den[DW-1] ? (~den + DW'(1)) : den;
        p_num    = {n_mag, {OUT_FRAC_BITS{1'b0}}};
        rem_init = {{(RW-HW){1'b0}}, p_num[PW-1:QW]};
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= rem_init;
        low_reg[0] <= p_num[QW-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= d_mag;
        neg_reg[0] <= num[DW-1] ^ den[DW-1];
        // high part already at or above the divisor: quotient needs more than QW bits
        sat_reg[0] <= rem_init >= {1'b0, d_mag};
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [RW-1:0] rem_sh;
        logic [RW:0]   diff;

        assign rem_sh = {rem_reg[i][RW-2:0], low_reg[i][QW-1]};
        assign diff   = {1'b0, rem_sh} - {2'b00, d_reg[i]};

        always_ff @(posedge clk)
        begin
            rem_reg[i+1] <= diff[RW] ? rem_sh : diff[RW-1:0];
            low_reg[i+1] <= {low_reg[i][QW-2:0], 1'b0};
            q_reg[i+1]   <= {q_reg[i][QW-2:0], ~diff[RW]};
            d_reg[i+1]   <= d_reg[i];
            neg_reg[i+1] <= neg_reg[i];
            sat_reg[i+1] <= sat_reg[i];
        end
    end

    always_comb
    begin
        res_next.sat = sat_reg[QW] ||
                       (q_reg[QW] > (neg_reg[QW] ? SAT_NEG : SAT_POS));
        if (res_next.sat)
            res_next.value = neg_reg[QW] ? SAT_NEG : SAT_POS;
        else if (neg_reg[QW])
            res_next.value = ~q_reg[QW] + QW'(1);
        else
            res_next.value = q_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
